/* rtl/core/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, command and status codes and sequencer state type for the
// bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [2:0] {
		SEQ_IDLE = 3'b001,
		SEQ_SRCH = 3'b010,
		SEQ_DONE = 3'b100
	} seq_state_t;

endpackage

/* rtl/core/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Double-ended queue of up to DEPTH signed 32-bit values in a circular store,
// with a linear search that walks the store one comparison per cycle.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, cmd, value            | in
//  result  | out_valid, out_ready, status, found,      | out
//          | found_position, element_count             |
//
//  Insert, remove and unused codes: the item is accepted and applied, then the
//  result is shown from the next cycle; the next item is taken once the
//  result has been taken. Search: the walk is set by the single memory read
//  port and the one comparator walking the store from the front. Reset clears
//  the front pointer, the count, the sequencer and the compare valid flag
//  only; store contents are undefined until written. A stalled result holds.
//
module bounded_deque_with_search #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bdq_pkg::CMD_W-1:0]     cmd,
	input  logic signed [bdq_pkg::VALUE_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bdq_pkg::STATUS_W-1:0]  status,
	output logic                          found,
	output logic [bdq_pkg::POS_W-1:0]     found_position,
	output logic [bdq_pkg::COUNT_W-1:0]   element_count
);
	import bdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	// circular store: one write and one registered read port
	logic [VALUE_W-1:0] mem [DEPTH];

	seq_state_t state_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;

	logic [VALUE_W-1:0] value_q;

	// search walk: issue side and compare side
	logic [IDX_W-1:0]   rd_slot_q;
	logic [CNT_W-1:0]   rd_off_q;
	logic [VALUE_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]   cmp_off_s1;
	logic               cmp_vld_s1;

	// result registers
	logic [STATUS_W-1:0] status_q;
	logic                found_q;
	logic [IDX_W-1:0]    pos_q;

	logic in_acc;
	logic out_acc;
	logic is_full;
	logic is_empty;
	logic rd_issue;
	logic cmp_hit;
	logic cmp_last;

	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] rd_slot_inc;
	logic [IDX_W:0]   back_sum;
	logic [IDX_W:0]   back_wrap;
	logic [IDX_W-1:0] back_slot;

	logic             wr_en;
	logic [IDX_W-1:0] wr_slot;

	logic [IDX_W+POS_W-1:0] pos_ext;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	assign in_ready  = (state_q == SEQ_IDLE);
	assign out_valid = (state_q == SEQ_DONE);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	// neighbouring slots with wrap at the store boundary
	assign front_dec   = (front_q == '0) ? LAST_SLOT : front_q - IDX_W'(1);
	assign front_inc   = (front_q == LAST_SLOT) ? '0 : front_q + IDX_W'(1);
	assign rd_slot_inc = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + IDX_W'(1);

	// back slot = front + count, one compare and subtract (count below DEPTH here)
	assign back_sum  = {1'b0, front_q} + {1'b0, count_q[IDX_W-1:0]};
	assign back_wrap = (back_sum >= DEPTH_X) ? back_sum - DEPTH_X : back_sum;
	assign back_slot = back_wrap[IDX_W-1:0];

	// store writes happen in the accept cycle of an insert that fits
	always_comb begin
		wr_en   = 1'b0;
		wr_slot = back_slot;
		if (in_acc && !is_full) begin
			case (cmd)
				CMD_PUSH_FRONT: begin
					wr_en   = 1'b1;
					wr_slot = front_dec;
				end
				CMD_PUSH_BACK: begin
					wr_en   = 1'b1;
					wr_slot = back_slot;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// issue a read while stored offsets remain; compare in the next cycle
	assign rd_issue = (state_q == SEQ_SRCH) && (rd_off_q != count_q);
	assign cmp_hit  = cmp_vld_s1 && (rd_data_s1 == value_q);
	assign cmp_last = cmp_vld_s1 && ((CNT_W'(cmp_off_s1) + CNT_W'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= value;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_slot_q];
		end
	end

	// control: sequencer, pointers, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				SEQ_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					if (in_acc) begin
						case (cmd)
							CMD_PUSH_FRONT: begin
								state_q <= SEQ_DONE;
								if (!is_full) begin
									front_q <= front_dec;
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_PUSH_BACK: begin
								state_q <= SEQ_DONE;
								if (!is_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_POP_FRONT: begin
								state_q <= SEQ_DONE;
								if (!is_empty) begin
									front_q <= front_inc;
									count_q <= count_q - CNT_W'(1);
								end
							end
							CMD_POP_BACK: begin
								state_q <= SEQ_DONE;
								if (!is_empty) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							CMD_SEARCH: begin
								// an empty store answers at once
								state_q <= is_empty ? SEQ_DONE : SEQ_SRCH;
							end
							default: begin
								state_q <= SEQ_DONE;
							end
						endcase
					end
				end
				SEQ_SRCH: begin
					if (cmp_hit || cmp_last) begin
						state_q    <= SEQ_DONE;
						cmp_vld_s1 <= 1'b0;
					end else begin
						cmp_vld_s1 <= rd_issue;
					end
				end
				SEQ_DONE: begin
					cmp_vld_s1 <= 1'b0;
					if (out_acc) begin
						state_q <= SEQ_IDLE;
					end
				end
				default: begin
					state_q    <= SEQ_IDLE;
					cmp_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// payload: search walk and result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			value_q   <= value;
			rd_slot_q <= front_q;
			rd_off_q  <= '0;
			found_q   <= 1'b0;
			pos_q     <= '0;
			case (cmd)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					status_q <= is_full ? STAT_FULL : STAT_OK;
				end
				CMD_POP_FRONT, CMD_POP_BACK: begin
					status_q <= is_empty ? STAT_EMPTY : STAT_OK;
				end
				default: begin
					status_q <= STAT_OK;
				end
			endcase
		end
		if (rd_issue) begin
			rd_slot_q  <= rd_slot_inc;
			rd_off_q   <= rd_off_q + CNT_W'(1);
			cmp_off_s1 <= rd_off_q[IDX_W-1:0];
		end
		// first match wins: the walk stops on it
		if ((state_q == SEQ_SRCH) && cmp_hit) begin
			found_q <= 1'b1;
			pos_q   <= cmp_off_s1;
		end
	end

	// fields wrap to their port widths for larger stores
	assign pos_ext = {{POS_W{1'b0}}, pos_q};
	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};

	assign status         = status_q;
	assign found          = found_q;
	assign found_position = pos_ext[POS_W-1:0];
	assign element_count  = cnt_ext[COUNT_W-1:0];

endmodule

/* rtl/core/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the bounded deque with search, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [bdq_pkg::CMD_W-1:0]     cmd,
	input logic signed [bdq_pkg::VALUE_W-1:0] value,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bdq_pkg::STATUS_W-1:0]  status,
	input logic                          found,
	input logic [bdq_pkg::POS_W-1:0]     found_position,
	input logic [bdq_pkg::COUNT_W-1:0]   element_count
);
	import bdq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
			&& $stable(found_position) && $stable(element_count))
		else $error("result changed while stalled");

	// one item in flight: never ready while a result is shown
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");

	// an accepted item drops ready for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready straight after accept");

	// a failed status never comes with a match
	a_fail_nofind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> !found)
		else $error("found set with failed status");

	// no match reports position zero
	a_nofind_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (found_position == '0))
		else $error("position set without match");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (.*);

/* test/bounded_deque_with_search_test.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search_test
// Self-checking test of the bounded deque with search. A mirror of the store
// predicts every result. Directed items cover the empty and full store, the
// extreme values and the unused command codes. Random phases then grow, shrink
// and churn the store with random gaps on the input side and random stalls on
// the result side.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;   // cycles with no handshake on either side
	localparam int SETTLE      = DEPTH + 8;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [POS_W-1:0]    position;
		logic [COUNT_W-1:0]  count;
	} outcome_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [CMD_W-1:0]           cmd;
	logic signed [VALUE_W-1:0]  value;
	logic                       out_valid;
	logic                       out_ready;
	logic [STATUS_W-1:0]        status;
	logic                       found;
	logic [POS_W-1:0]           found_position;
	logic [COUNT_W-1:0]         element_count;

	// mirror of the deque: slots, front slot and occupancy
	logic signed [VALUE_W-1:0]  mirror_slots [DEPTH];
	int                         mirror_front;
	int                         mirror_count;

	outcome_t                   expected_outcomes [$];

	// idling switches, changed per phase
	bit                         gaps_on;
	bit                         stalls_on;

	int                         error_count;
	int                         results_seen;
	int                         idle_cycles = 0;
	int                         cmd_tally [8];
	int                         search_hits;
	int                         full_refusals;
	int                         empty_refusals;

	bounded_deque_with_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found(found),
		.found_position(found_position),
		.element_count(element_count)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Apply one command to the mirror and return the result it must produce.
	function automatic outcome_t predict_outcome(logic [CMD_W-1:0] c,
			logic signed [VALUE_W-1:0] v);
		outcome_t o;
		o = '0;
		o.status = STAT_OK;
		case (c)
			CMD_PUSH_FRONT: begin
				if (mirror_count >= DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
					mirror_slots[mirror_front] = v;
					mirror_count++;
				end
			end
			CMD_PUSH_BACK: begin
				if (mirror_count >= DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					mirror_slots[(mirror_front + mirror_count) % DEPTH] = v;
					mirror_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (mirror_count == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					mirror_front = (mirror_front + 1) % DEPTH;
					mirror_count--;
				end
			end
			CMD_POP_BACK: begin
				if (mirror_count == 0)
					o.status = STAT_EMPTY;
				else
					mirror_count--;
			end
			CMD_SEARCH: begin
				// first match counted from the front wins
				for (int i = 0; i < mirror_count; i++) begin
					if (mirror_slots[(mirror_front + i) % DEPTH] == v) begin
						o.found    = 1'b1;
						o.position = POS_W'(i);
						break;
					end
				end
			end
			default: ;   // spare codes change nothing
		endcase
		o.count = COUNT_W'(mirror_count);
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Offer one item after a random gap, hold it until taken, then predict.
	// Valid is left high on return so that a back-to-back item does not
	// lower and raise it within one time step.
	task automatic send_item(logic [CMD_W-1:0] c, logic signed [VALUE_W-1:0] v);
		int       gap;
		outcome_t o;
		gap = gaps_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		o = predict_outcome(c, v);
		expected_outcomes.push_back(o);
		cmd_tally[c]++;
		if (o.status == STAT_FULL)
			full_refusals++;
		if (o.status == STAT_EMPTY)
			empty_refusals++;
		if (o.found)
			search_hits++;
	endtask

	// Withdraw valid and hold off until every outstanding result is back.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Mostly a small pool so that duplicates and search hits are common.
	function automatic logic signed [VALUE_W-1:0] random_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $signed(VALUE_W'($urandom_range(0, 7))) - 32'sd3;
		if (r < 65)
			return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
		return $urandom;
	endfunction

	// Search key: a stored element most of the time, otherwise anything.
	function automatic logic signed [VALUE_W-1:0] search_key();
		if (mirror_count > 0 && $urandom_range(0, 99) < 60)
			return mirror_slots[(mirror_front + $urandom_range(0, mirror_count - 1))
				% DEPTH];
		return random_value();
	endfunction

	function automatic logic [CMD_W-1:0] CMD_CMD_spare();
		return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
	endfunction

	// One random phase; push_pct and pop_pct steer the occupancy, the rest
	// goes to searches and a sprinkle of spare codes.
	task automatic run_phase(int items, int push_pct, int pop_pct);
		int unsigned r;
		logic [CMD_W-1:0] c;
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				c = CMD_CMD_spare();
				send_item(c, $urandom);
			end else if (r < 4 + push_pct) begin
				c = ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
				send_item(c, random_value());
			end else if (r < 4 + push_pct + pop_pct) begin
				c = ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
				send_item(c, random_value());
			end else begin
				send_item(CMD_SEARCH, search_key());
			end
		end
	endtask

	// Draw fresh idling switches; each is off in roughly one phase in four.
	task automatic pick_idling();
		gaps_on   = $urandom_range(0, 3) != 0;
		stalls_on = $urandom_range(0, 3) != 0;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Empty store: search misses, removals are refused, spare codes do nothing.
	task automatic test_empty_store();
		send_item(CMD_SEARCH, 32'sd0);
		send_item(CMD_POP_FRONT, 32'sd0);
		send_item(CMD_POP_BACK, VAL_MIN);
		send_item(CMD_SPARE_LO, VAL_MAX);
		send_item(CMD_SPARE_MID, 32'sd0);
		send_item(CMD_SPARE_HI, -32'sd1);
	endtask

	// Extreme values at both ends, searches that hit and miss, one removal each end.
	task automatic test_extreme_values();
		send_item(CMD_PUSH_FRONT, VAL_MIN);
		send_item(CMD_PUSH_BACK, VAL_MAX);
		send_item(CMD_PUSH_FRONT, 32'sd0);
		send_item(CMD_PUSH_BACK, -32'sd1);
		send_item(CMD_SEARCH, VAL_MIN);
		send_item(CMD_SEARCH, -32'sd1);
		send_item(CMD_SEARCH, 32'sd12345);
		send_item(CMD_POP_FRONT, 32'sd0);
		send_item(CMD_POP_BACK, 32'sd0);
	endtask

	// Fill to the brim with duplicates, then try to insert at both ends.
	task automatic test_full_store();
		int k;
		k = 0;
		while (mirror_count < DEPTH) begin
			send_item((k % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 32'(k % 3));
			k++;
		end
		send_item(CMD_PUSH_FRONT, VAL_MAX);
		send_item(CMD_PUSH_BACK, VAL_MIN);
		send_item(CMD_SEARCH, VAL_MAX);   // refused insert; the earlier copy still matches
		send_item(CMD_SEARCH, 32'sd2);
		send_item(CMD_POP_FRONT, 32'sd0);
		send_item(CMD_POP_BACK, 32'sd0);
	endtask

	// Swing the store between full and empty so both refusals recur.
	task automatic test_fill_and_drain();
		for (int round = 0; round < 3; round++) begin
			pick_idling();
			run_phase(120, 70, 10);
			pick_idling();
			run_phase(120, 10, 70);
		end
	endtask

	// Hold the input back mid-stream until every result is home.
	task automatic test_drain_pause();
		pick_idling();
		run_phase(60, 45, 25);
		pause_until_drained();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		run_phase(60, 35, 35);
	endtask

	// Balanced churn across phases with changing idling.
	task automatic test_random_mix();
		for (int p = 0; p < 9; p++) begin
			pick_idling();
			run_phase(100, 35, 30);
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checker: draw a stall per result, take it, compare field by field
	// ------------------------------------------------------------------------
	task automatic compare_field(string field, int want, int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field,
				want, got);
		end
	endtask

	initial begin : result_checker
		int       stall;
		outcome_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = stalls_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (expected_outcomes.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing expected, status %0d count %0d",
					$realtime, status, element_count);
			end else begin
				want = expected_outcomes.pop_front();
				compare_field("status", int'(want.status), int'(status));
				compare_field("found", int'(want.found), int'(found));
				compare_field("found_position", int'(want.position),
					int'(found_position));
				compare_field("element_count", int'(want.count), int'(element_count));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: count cycles in which neither channel moves an item
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$realtime, STALL_LIMIT, expected_outcomes.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_PUSH_FRONT;
		value        = '0;
		mirror_front = 0;
		mirror_count = 0;
		error_count  = 0;
		results_seen = 0;
		gaps_on      = 1'b1;
		stalls_on    = 1'b1;
		foreach (cmd_tally[i])
			cmd_tally[i] = 0;
		search_hits    = 0;
		full_refusals  = 0;
		empty_refusals = 0;

		// hold reset asserted, then release it once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_extreme_values();
		test_full_store();
		test_fill_and_drain();
		test_drain_pause();
		test_random_mix();

		// drop valid, let the last results arrive, then watch for stray ones
		pause_until_drained();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d results: %0d inserts, %0d removals, %0d searches (%0d hits)",
			results_seen, cmd_tally[CMD_PUSH_FRONT] + cmd_tally[CMD_PUSH_BACK],
			cmd_tally[CMD_POP_FRONT] + cmd_tally[CMD_POP_BACK], cmd_tally[CMD_SEARCH],
			search_hits);
		$display("Refused %0d inserts into a full store and %0d removals from an empty one",
			full_refusals, empty_refusals);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/bdq_pkg.sv
rtl/core/bounded_deque_with_search.sv
rtl/core/bdq_checker.sv
test/bounded_deque_with_search_test.sv
